/* rtl/core/sbda_pkg.sv */
// Shared types and constants for the signed binary to decimal ASCII converter.
package sbda_pkg;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	typedef struct packed {
		logic load;
		logic dabble;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} sbda_cmd_t;

	typedef struct packed {
		logic bits_done;
		logic lead_zero;
		logic neg;
		logic last_digit;
		logic out_free;
	} sbda_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_SKIP  = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_DIGIT = 5'b10000
	} sbda_state_t;

endpackage

/* rtl/core/sbda_in_if.sv */
// Input channel: one signed integer per transfer.
interface sbda_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

/* rtl/core/sbda_out_if.sv */
// Output channel: one ASCII character per transfer.
interface sbda_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;
	logic [3:0] text_length;

	modport source (output valid, output character, output last, output text_length,
		input ready);
	modport sink (input valid, input character, input last, input text_length,
		output ready);
endinterface

/* rtl/core/signed_binary_to_decimal_ascii.sv */
// Top level of the signed binary to decimal ASCII converter.
// Usage:
//   operand: one two's complement value of VALUE_WIDTH bits per transfer.
//   text: the decimal text of that value, one ASCII character per transfer,
//   most significant first; a negative value starts with '-', zero is "0".
//   The final character has last set and text_length holds the character count.
// Timing:
//   A value is taken only while the converter is idle, in a cycle of its own.
//   Conversion is a shift-add-3 pass of one bit per cycle; then leading zero
//   digits are stripped, the strip is left, and the sign and digits are sent.
//   The last character sits in an output register, so the next value is
//   accepted while it still waits to be taken.
// Reset clears the sequencer and the output valid; nothing else is kept.
// A stalled receiver holds the current character and pauses the sequence.
module signed_binary_to_decimal_ascii
	import sbda_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	sbda_in_if.sink    operand,
	sbda_out_if.source text
);

	sbda_cmd_t cmd;
	sbda_sts_t sts;

	sbda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operand.valid),
		.in_ready (operand.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbda_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (operand.value),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (text.ready),
		.out_valid   (text.valid),
		.character   (text.character),
		.last        (text.last),
		.text_length (text.text_length)
	);

endmodule

/* rtl/core/sbda_ctrl.sv */
// Sequencer: convert, strip leading zeros, then emit the sign if negative and the digits.
module sbda_ctrl
	import sbda_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sbda_sts_t sts,
	output sbda_cmd_t cmd
);

	sbda_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (sts.bits_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (sts.lead_zero) begin
					cmd.skip = 1'b1;
				end else if (sts.neg) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.last_digit) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/sbda_dp.sv */
// Datapath: magnitude, shift-add-3 BCD register, counters and output register.
module sbda_dp
	import sbda_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] value,
	input  sbda_cmd_t              cmd,
	output sbda_sts_t              sts,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [7:0]             character,
	output logic                   last,
	output logic [3:0]             text_length
);

	// decimal digits of 2^(VALUE_WIDTH-1)
	localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCDW = NDIG * 4;
	localparam int BW   = $clog2(VALUE_WIDTH);
	localparam int RW   = $clog2(NDIG + 1);
	localparam int LW0  = $clog2(NDIG + 2);
	localparam int LW   = (LW0 > 4) ? LW0 : 4;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCDW-1:0]        bcd_q;
	logic [BCDW-1:0]        bcd_adj;
	logic [BW-1:0]          bit_cnt_q;
	logic [RW-1:0]          rem_q;
	logic [LW-1:0]          len_q;
	logic [LW-1:0]          len_next;
	logic                   neg_q;
	logic [3:0]             top_digit;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic [3:0]             len_out_q;
	logic                   out_free;

	assign top_digit = bcd_q[BCDW-1 -: 4];
	assign len_next  = len_q + LW'(1);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q     <= value[VALUE_WIDTH-1];
			mag_q     <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
			bcd_q     <= '0;
			bit_cnt_q <= '0;
			rem_q     <= RW'(NDIG);
			len_q     <= '0;
		end else if (cmd.dabble) begin
			{bcd_q, mag_q} <= {bcd_adj[BCDW-2:0], mag_q, 1'b0};
			bit_cnt_q      <= bit_cnt_q + BW'(1);
		end else if (cmd.skip) begin
			bcd_q <= {bcd_q[BCDW-5:0], 4'd0};
			rem_q <= rem_q - RW'(1);
		end else if (cmd.emit_sign) begin
			len_q <= len_next;
		end else if (cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCDW-5:0], 4'd0};
			rem_q <= rem_q - RW'(1);
			len_q <= len_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q    <= ASCII_MINUS;
			last_q    <= 1'b0;
			len_out_q <= 4'd0;
		end else if (cmd.emit_digit) begin
			char_q    <= ASCII_ZERO + {4'd0, top_digit};
			last_q    <= (rem_q == RW'(1));
			len_out_q <= (rem_q == RW'(1)) ? len_next[3:0] : 4'd0;
		end
	end

	assign sts.bits_done  = (bit_cnt_q == BW'(VALUE_WIDTH - 1));
	assign sts.lead_zero  = (top_digit == 4'd0) && (rem_q != RW'(1));
	assign sts.neg        = neg_q;
	assign sts.last_digit = (rem_q == RW'(1));
	assign sts.out_free   = out_free;

	assign out_valid   = out_valid_q;
	assign character   = char_q;
	assign last        = last_q;
	assign text_length = len_out_q;

endmodule

/* bench/tb_signed_binary_to_decimal_ascii.sv */
// Self-checking bench: random and corner integers in, decimal ASCII text checked per character.
module tb_signed_binary_to_decimal_ascii;
	import sbda_pkg::*;

	localparam int VW = 32;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [3:0] len;
	} text_char_t;

	class decimal_text_board;
		text_char_t chars_due[$];
		int errors = 0;

		// Queue the characters that the decimal text of v should produce.
		function void queue_text_of(logic [VW-1:0] v);
			logic neg;
			logic [VW-1:0] mag;
			logic [7:0] digit;
			logic [7:0] digits[$];
			int text_len;
			text_char_t c;
			neg = v[VW-1];
			mag = neg ? (~v + 1'b1) : v;
			do begin
				digit = 8'(mag % 10);
				digits.push_front(ASCII_ZERO + digit);
				mag = mag / 10;
			end while (mag != 0);
			text_len = digits.size() + (neg ? 1 : 0);
			if (neg) begin
				c.ch = ASCII_MINUS;
				c.last = (text_len == 1);
				c.len = (text_len == 1) ? text_len[3:0] : 4'd0;
				chars_due.push_back(c);
			end
			for (int i = 0; i < digits.size(); i++) begin
				c.ch = digits[i];
				c.last = (i == digits.size() - 1);
				c.len = c.last ? text_len[3:0] : 4'd0;
				chars_due.push_back(c);
			end
		endfunction

		function void check_char(logic [7:0] ch, logic last, logic [3:0] len);
			text_char_t e;
			if (chars_due.size() == 0) begin
				errors++;
				if (errors <= 50)
					$display("%0t: unexpected character, expected none, got %h last %b len %0d",
						$time, ch, last, len);
				return;
			end
			e = chars_due.pop_front();
			if (ch !== e.ch) begin
				errors++;
				if (errors <= 50)
					$display("%0t: character expected %h got %h", $time, e.ch, ch);
			end
			if (last !== e.last) begin
				errors++;
				if (errors <= 50)
					$display("%0t: last expected %b got %b", $time, e.last, last);
			end
			if (len !== e.len) begin
				errors++;
				if (errors <= 50)
					$display("%0t: text_length expected %0d got %0d", $time, e.len, len);
			end
		endfunction

		function int outstanding();
			return chars_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   rst_done = 1'b0;

	sbda_in_if #(.VALUE_WIDTH(VW)) operand_ch();
	sbda_out_if text_ch();

	signed_binary_to_decimal_ascii #(.VALUE_WIDTH(VW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand_ch),
		.text(text_ch)
	);

	decimal_text_board board = new;

	logic [VW-1:0] directed_values [0:23] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
		32'd100, -32'sd100, 32'd12345, -32'sd67890, 32'd999999999, 32'd1000000000,
		-32'sd999999999, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
		32'h7FFF_FFFE, 32'h4000_0000, 32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA
	};

	always #5 clk = ~clk;

	task automatic send_value(input logic [VW-1:0] v);
		operand_ch.valid <= 1'b1;
		operand_ch.value <= v;
		do @(posedge clk); while (!operand_ch.ready);
		board.queue_text_of(v);
	endtask

	task automatic wait_drained();
		operand_ch.valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	initial begin
		operand_ch.valid <= 1'b0;
		operand_ch.value <= '0;
		text_ch.ready <= 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		rst_done = 1'b1;
	end

	// Sender: directed corners, then bursts of random values with random gaps.
	initial begin
		int sent;
		int burst;
		int sel;
		int nd;
		longint lo;
		longint hi;
		logic [VW-1:0] v;
		wait (rst_done);
		foreach (directed_values[i]) begin
			send_value(directed_values[i]);
			if ($urandom_range(0, 3) == 0) begin
				operand_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 60)) @(posedge clk);
			end
		end
		wait_drained();
		@(posedge clk);
		sent = 0;
		while (sent < 500) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				sel = $urandom_range(0, 9);
				if (sel < 4) begin
					v = $urandom();
				end else if (sel < 9) begin
					nd = $urandom_range(1, 10);
					lo = 1;
					repeat (nd - 1) lo = lo * 10;
					hi = (nd == 10) ? 64'd2147483647 : lo * 10 - 1;
					v = $urandom_range(hi[31:0], lo[31:0]);
					if ($urandom_range(0, 1)) v = -v;
				end else begin
					case ($urandom_range(0, 2))
						0: v = 32'h8000_0000 + $urandom_range(0, 20);
						1: v = 32'h7FFF_FFFF - $urandom_range(0, 20);
						default: begin
							lo = 1;
							repeat ($urandom_range(0, 9)) lo = lo * 10;
							v = lo[31:0] - 32'd1 + $urandom_range(0, 2);
							if ($urandom_range(0, 1)) v = -v;
						end
					endcase
				end
				send_value(v);
				sent++;
				if (sent == 250) begin
					wait_drained();
					@(posedge clk);
				end
			end
			if ($urandom_range(0, 4) != 0) begin
				operand_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 70)) @(posedge clk);
			end
		end
		wait_drained();
		repeat (64) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("signed_binary_to_decimal_ascii regression: pass");
		else
			$display("signed_binary_to_decimal_ascii regression: fail");
		$finish;
	end

	// Receiver: checks each transfer, ready follows changing stall modes plus one long hold.
	initial begin
		int mode;
		int mode_left;
		int phase;
		int chars_taken;
		int hold_left;
		bit hold_done;
		logic nxt;
		mode = 0;
		mode_left = 0;
		phase = 0;
		chars_taken = 0;
		hold_left = 0;
		hold_done = 1'b0;
		wait (rst_done);
		forever begin
			@(posedge clk);
			if (text_ch.valid && text_ch.ready) begin
				board.check_char(text_ch.character, text_ch.last, text_ch.text_length);
				chars_taken++;
			end
			if (!hold_done && chars_taken >= 600) begin
				hold_done = 1'b1;
				hold_left = 500;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 4);
				mode_left = $urandom_range(64, 256);
			end
			mode_left--;
			phase++;
			case (mode)
				0: nxt = 1'b1;
				1: nxt = 1'($urandom_range(0, 1));
				2: nxt = ($urandom_range(0, 99) < 85);
				3: nxt = (phase % 5 != 0);
				default: nxt = ($urandom_range(0, 3) == 0);
			endcase
			if (hold_left > 0) begin
				nxt = 1'b0;
				hold_left--;
			end
			text_ch.ready <= nxt;
		end
	end

	initial begin
		#5_000_000;
		$display("signed_binary_to_decimal_ascii regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/sbda_pkg.sv
rtl/core/sbda_in_if.sv
rtl/core/sbda_out_if.sv
rtl/core/sbda_ctrl.sv
rtl/core/sbda_dp.sv
rtl/core/signed_binary_to_decimal_ascii.sv
bench/tb_signed_binary_to_decimal_ascii.sv
